FILE: rtl/core/spq_pkg.sv
// Shared types, codes and the ordering function of the sorted priority queue.
package spq_pkg;

  localparam int IdWidth = 16;
  localparam int UrgWidth = 16;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_SERVED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic [UrgWidth-1:0] urgency;
    logic [IdWidth-1:0]  patient_id;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t fresh;
  } spq_cmd_t;

  // True when the new entry belongs ahead of the stored entry.
  function automatic logic goes_before(entry_t fresh, entry_t stored);
    logic result;
    result = (stored.urgency < fresh.urgency) ||
             ((stored.urgency == fresh.urgency) &&
              (stored.patient_id >= fresh.patient_id));
    return result;
  endfunction

endpackage

FILE: rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic     clk,
  input  spq_cmd_t cmd,
  input  logic     occupied,
  input  logic     prev_ins,
  input  entry_t   prev_entry,
  input  entry_t   next_entry,
  output entry_t   entry,
  output logic     ins
);

  entry_t entry_next;

  // An empty slot always accepts; the flag is monotonic along a sorted chain.
  assign ins = !occupied || goes_before(cmd.fresh, entry);

  always_comb begin
    entry_next = entry;
    if (cmd.push) begin
      if (prev_ins) begin
        entry_next = prev_entry;
      end else if (ins) begin
        entry_next = cmd.fresh;
      end
    end else if (cmd.pop) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: rtl/core/sorted_priority_queue_unit.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// A push when not full or a pop when not empty updates all cells; one transaction
// per cycle is taken while the result register is free or being drained.
// A result (pop, or rejected push) appears at out_valid the cycle after acceptance.
// Reset clears the entry count and the result valid flag; slot contents
// stay undefined until written and are never read while unoccupied.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY = 64
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] patient_id,
  input  logic [15:0] urgency,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] served_id
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            accept;
  logic            is_pop;
  logic            full;
  logic            empty;
  logic            res_valid;
  status_t         res_status;
  logic [15:0]     res_id;
  status_t         status_r;
  spq_cmd_t        cmd;

  entry_t             cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_ins;
  logic [CAPACITY-1:0] cell_occ;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_pop   = (func_t'(func) == FUNC_POP);
  assign full     = (count == CntW'(CAPACITY));
  assign empty    = (count == '0);

  assign cmd.push             = accept && !is_pop && !full;
  assign cmd.pop              = accept && is_pop && !empty;
  assign cmd.fresh.urgency    = urgency;
  assign cmd.fresh.patient_id = patient_id;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   p_ins;
    entry_t p_entry;
    entry_t n_entry;

    assign cell_occ[i] = (count > CntW'(i));

    if (i == 0) begin : g_first
      assign p_ins   = 1'b0;
      assign p_entry = cmd.fresh;
    end else begin : g_mid
      assign p_ins   = cell_ins[i-1];
      assign p_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_entry = cell_entry[i];
    end else begin : g_inner
      assign n_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (cell_occ[i]),
      .prev_ins   (p_ins),
      .prev_entry (p_entry),
      .next_entry (n_entry),
      .entry      (cell_entry[i]),
      .ins        (cell_ins[i])
    );
  end

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CntW'(1);
    end else if (cmd.pop) begin
      count_next = count - CntW'(1);
    end
  end

  always_comb begin
    res_valid  = accept && (is_pop || full);
    res_status = ST_SERVED;
    res_id     = '0;
    if (is_pop) begin
      if (empty) begin
        res_status = ST_EMPTY;
      end else begin
        res_id = cell_entry[0].patient_id;
      end
    end else begin
      res_status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (res_valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status_r  <= res_status;
      served_id <= res_id;
    end
  end

  assign status = status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_pop && full) |=> (count == $past(count)) && out_valid &&
    (status_r == ST_FULL))
    else $error("rejected push changed the queue or gave no full status");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && is_pop && empty) |=> out_valid && (status_r == ST_EMPTY) &&
    (served_id == '0))
    else $error("pop on empty queue gave wrong result");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> (count == $past(count) + CntW'(1)) && !out_valid == !$past(out_valid &&
    out_stall))
    else $error("successful push miscounted or produced a result");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CntW'(2)) |-> goes_before(cell_entry[0], cell_entry[1]) ||
    (cell_entry[0] == cell_entry[1]))
    else $error("head entry is not ahead of the second entry");
`endif

endmodule
